// ===== hw/rtl/go_to_goal_pi_controller_defines.svh =====
// Assertion macros used by the controller RTL.
`ifndef GO_TO_GOAL_PI_CONTROLLER_DEFINES_SVH
`define GO_TO_GOAL_PI_CONTROLLER_DEFINES_SVH

// Checks that a condition implies a consequence in the same cycle.
`define G2G_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checks that a condition implies a consequence in the following cycle.
`define G2G_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/g2g_pkg.sv =====
package g2g_pkg;

  // CORDIC length and angle table size.
  localparam int CordicSteps = 16;
  localparam int AtanEntries = 24;
  localparam int NumSteps = (CordicSteps < AtanEntries) ? CordicSteps : AtanEntries;
  localparam int StepW = $clog2(NumSteps + 1);

  // CORDIC datapath width: 17-bit offset times 256, plus growth.
  localparam int CordW = 28;
  localparam int ZW = 33;

  localparam logic signed [ZW-1:0] HalfPiQ30 = 33'sd1686629713;
  localparam logic [15:0] InvGainQ16 = 16'd39797;

  // Multiplier serial width: one bit of multiplier per cycle.
  localparam int MulW = 34;
  localparam int MulCntW = $clog2(MulW + 1);

  typedef enum logic [2:0] {
    REG_GOAL_X, REG_GOAL_Y, REG_ARRIVE_TOL, REG_ANG_GAIN,
    REG_LIN_INT_GAIN, REG_ANG_INT_GAIN, REG_STEP_TIME, REG_NONE
  } reg_idx_t;

  function automatic logic signed [ZW-1:0] atan_q30(input logic [4:0] i);
    logic signed [ZW-1:0] v;
    v = '0;
    unique case (i)
      5'd0: v = 33'sd843314857;
      5'd1: v = 33'sd497837829;
      5'd2: v = 33'sd263043837;
      5'd3: v = 33'sd133525159;
      5'd4: v = 33'sd67021687;
      5'd5: v = 33'sd33543516;
      5'd6: v = 33'sd16775851;
      5'd7: v = 33'sd8388437;
      5'd8: v = 33'sd4194283;
      5'd9: v = 33'sd2097149;
      5'd10: v = 33'sd1048576;
      5'd11: v = 33'sd524288;
      5'd12: v = 33'sd262144;
      5'd13: v = 33'sd131072;
      5'd14: v = 33'sd65536;
      5'd15: v = 33'sd32768;
      5'd16: v = 33'sd16384;
      5'd17: v = 33'sd8192;
      5'd18: v = 33'sd4096;
      5'd19: v = 33'sd2048;
      5'd20: v = 33'sd1024;
      5'd21: v = 33'sd512;
      5'd22: v = 33'sd256;
      5'd23: v = 33'sd128;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Handshake between sequencer and the serial multiplier.
  typedef struct packed {
    logic start;
    logic signed [MulW-1:0] a;
    logic [MulW-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mul_stat_t;

endpackage

// ===== hw/rtl/g2g_cordic.sv =====
module g2g_cordic (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic signed [16:0] dx,
  input  logic signed [16:0] dy,
  output logic done,
  output logic signed [g2g_pkg::CordW-1:0] x_out,
  output logic signed [g2g_pkg::ZW-1:0] z_out
);
  import g2g_pkg::*;

  logic signed [CordW-1:0] x_r, y_r, x_nxt, y_nxt;
  logic signed [ZW-1:0] z_r, z_nxt;
  logic [StepW-1:0] i_r, i_nxt;
  logic busy_r, busy_nxt, done_r, done_nxt;
  logic signed [CordW-1:0] x0, y0, xs, ys;

  // Scale the offsets by 256 into the datapath width.
  always_comb begin
    x0 = CordW'(dx) <<< 8;
    y0 = CordW'(dy) <<< 8;
  end

  assign xs = x_r >>> i_r;
  assign ys = y_r >>> i_r;

  // Pre-rotation into the right half plane on start, then one micro-rotation per cycle while busy.
  always_comb begin
    x_nxt = x_r;
    y_nxt = y_r;
    z_nxt = z_r;
    i_nxt = i_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      i_nxt = '0;
      busy_nxt = (NumSteps != 0);
      done_nxt = (NumSteps == 0);
      if (x0 < 0) begin
        if (y0 >= 0) begin
          x_nxt = y0; y_nxt = -x0; z_nxt = HalfPiQ30;
        end else begin
          x_nxt = -y0; y_nxt = x0; z_nxt = -HalfPiQ30;
        end
      end else begin
        x_nxt = x0; y_nxt = y0; z_nxt = '0;
      end
    end else if (busy_r) begin
      if (y_r >= 0) begin
        x_nxt = x_r + ys; y_nxt = y_r - xs; z_nxt = z_r + atan_q30(5'(i_r));
      end else begin
        x_nxt = x_r - ys; y_nxt = y_r + xs; z_nxt = z_r - atan_q30(5'(i_r));
      end
      i_nxt = i_r + 1'b1;
      if (i_r == StepW'(NumSteps - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      i_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      i_r <= i_nxt;
    end
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
  end

  assign done = done_r;
  assign x_out = x_r;
  assign z_out = z_r;

endmodule

// ===== hw/rtl/g2g_mul.sv =====
// Shift-add multiplier: one bit of the unsigned operand per cycle.
module g2g_mul (
  input  logic clk,
  input  logic rst_n,
  input  g2g_pkg::mul_req_t req,
  output g2g_pkg::mul_stat_t stat,
  output logic signed [2*g2g_pkg::MulW-1:0] prod
);
  import g2g_pkg::*;

  logic signed [2*MulW-1:0] acc_r, acc_nxt, a_r, a_nxt;
  logic [MulW-1:0] b_r, b_nxt;
  logic [MulCntW-1:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt, done_r, done_nxt;

  always_comb begin
    acc_nxt = acc_r;
    a_nxt = a_r;
    b_nxt = b_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      acc_nxt = '0;
      a_nxt = (2*MulW)'(req.a);
      b_nxt = req.b;
      cnt_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (b_r[0]) acc_nxt = acc_r + a_r;
      a_nxt = a_r <<< 1;
      b_nxt = b_r >> 1;
      cnt_nxt = cnt_r + 1'b1;
      // Stop early once the remaining multiplier bits are zero.
      if (cnt_r == MulCntW'(MulW - 1) || (b_r >> 1) == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    a_r <= a_nxt;
    b_r <= b_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign prod = acc_r;

endmodule

// ===== hw/rtl/go_to_goal_pi_controller.sv =====
// Go-to-goal PI controller. Each input beat with op = 1 is a pose sample;
// the block runs an iterative CORDIC (one rotation per cycle, 16 steps) for
// distance and bearing, then chains up to six products on a shared bit-serial
// multiplier that takes one bit of a 16-bit gain per cycle and stops early
// once the remaining gain bits are zero. A sample within the arrival
// tolerance answers after the distance product; any other sample answers
// after the whole chain of products. A beat with op = 0 clears both
// integrals and answers with an all-zero result in the cycle after it is taken.
// One item is handled at a time; the result waits in an output register and
// the next beat is taken once it is gone.
module go_to_goal_pi_controller (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  logic [55:0] in_tdata, // op[0], pos_x[16:1], pos_y[32:17], heading[48:33]
  output logic out_tvalid,
  input  logic out_tready,
  output logic [39:0] out_tdata, // linear_speed[14:0], turn_rate[38:15], arrived[39]
  input  logic cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [15:0] cfg_wdata
);
  import g2g_pkg::*;
`include "go_to_goal_pi_controller_defines.svh"

  typedef enum logic [3:0] {
    S_IDLE, S_CORDIC, S_DIST, S_M_DI, S_M_HI, S_M_V, S_M_WP, S_M_WI, S_OUT
  } state_t;

  state_t state_r;
  logic signed [15:0] goal_x_r, goal_y_r;
  logic [14:0] tol_r;
  logic [15:0] ang_gain_r, lin_ig_r, ang_ig_r, step_r;
  logic [31:0] dint_r;
  logic signed [31:0] hint_r;
  logic signed [15:0] hd_r;
  logic signed [16:0] dx_r, dy_r;
  logic signed [ZW:0] err_r;
  logic [33:0] dist_r;
  logic signed [47:0] wacc_r;
  logic [14:0] lin_r;
  logic signed [23:0] ang_r;
  logic arr_r, out_valid_r, cstart_r;
  mul_req_t mreq_r;
  mul_stat_t mstat;
  logic signed [2*MulW-1:0] prod;
  logic cdone;
  logic signed [CordW-1:0] cx;
  logic signed [ZW-1:0] cz;
  logic in_acc;
  logic signed [ZW-1:0] bear_c;
  logic signed [2*MulW-1:0] di_sum, hi_sum, v_sum, w_sum;
  logic [33:0] dist_c;
  logic arrive_c, cordic_go, mul_go;

  g2g_cordic u_cordic (
    .clk(clk), .rst_n(rst_n), .start(cstart_r), .dx(dx_r), .dy(dy_r),
    .done(cdone), .x_out(cx), .z_out(cz)
  );

  g2g_mul u_mul (.clk(clk), .rst_n(rst_n), .req(mreq_r), .stat(mstat), .prod(prod));

  assign in_tready = (state_r == S_IDLE) && !out_valid_r;
  assign in_acc = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata = {arr_r, ang_r, lin_r};

  assign bear_c = (cz + ZW'(65536)) >>> 17;
  assign di_sum = (2*MulW)'(dint_r) + (prod >>> 16);
  assign hi_sum = (2*MulW)'(hint_r) + (prod >>> 16);
  assign v_sum = (2*MulW)'(dist_r) + (prod >>> 16);
  assign w_sum = (2*MulW)'(wacc_r) + (prod >>> 16);

  // Rounded distance from the scaled CORDIC magnitude, and the arrival test.
  assign dist_c = 34'((prod + (2*MulW)'(1 << 23)) >>> 24);
  assign arrive_c = dist_c <= 34'(tol_r);

  // Start pulses for the CORDIC and for the next serial product.
  assign cordic_go = in_acc && in_tdata[0];

  always_comb begin
    unique case (state_r)
      S_CORDIC: mul_go = cdone;
      S_DIST: mul_go = mstat.done && !arrive_c;
      S_M_DI, S_M_HI, S_M_V, S_M_WP: mul_go = mstat.done;
      default: mul_go = 1'b0;
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      goal_x_r <= 16'sd8192;
      goal_y_r <= 16'sd2048;
      tol_r <= 15'd20;
      ang_gain_r <= 16'd4096;
      lin_ig_r <= 16'd655;
      ang_ig_r <= 16'd0;
      step_r <= 16'd6554;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_GOAL_X: goal_x_r <= cfg_wdata;
        REG_GOAL_Y: goal_y_r <= cfg_wdata;
        REG_ARRIVE_TOL: tol_r <= cfg_wdata[14:0];
        REG_ANG_GAIN: ang_gain_r <= cfg_wdata;
        REG_LIN_INT_GAIN: lin_ig_r <= cfg_wdata;
        REG_ANG_INT_GAIN: ang_ig_r <= cfg_wdata;
        REG_STEP_TIME: step_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Sequencer: clears the integrals on op = 0; otherwise runs the CORDIC, then the chain of serial products.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
      cstart_r <= 1'b0;
      mreq_r.start <= 1'b0;
      dint_r <= '0;
      hint_r <= '0;
    end else begin
      cstart_r <= cordic_go;
      mreq_r.start <= mul_go;
      if (out_valid_r && out_tready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            hd_r <= in_tdata[48:33];
            dx_r <= 17'(goal_x_r) - 17'(signed'(in_tdata[16:1]));
            dy_r <= 17'(goal_y_r) - 17'(signed'(in_tdata[32:17]));
            if (!in_tdata[0]) begin
              dint_r <= '0;
              hint_r <= '0;
              lin_r <= '0; ang_r <= '0; arr_r <= 1'b0;
              out_valid_r <= 1'b1;
            end else begin
              state_r <= S_CORDIC;
            end
          end
        end
        S_CORDIC: begin
          if (cdone) begin
            err_r <= (ZW+1)'(bear_c) - (ZW+1)'(hd_r);
            mreq_r.a <= MulW'(cx);
            mreq_r.b <= MulW'(InvGainQ16);
            state_r <= S_DIST;
          end
        end
        S_DIST: begin
          if (mstat.done) begin
            dist_r <= dist_c;
            if (arrive_c) begin
              lin_r <= '0; ang_r <= '0; arr_r <= 1'b1;
              out_valid_r <= 1'b1;
              state_r <= S_IDLE;
            end else begin
              mreq_r.a <= MulW'(dist_c);
              mreq_r.b <= MulW'(step_r);
              state_r <= S_M_DI;
            end
          end
        end
        S_M_DI: begin
          if (mstat.done) begin
            dint_r <= (di_sum > (2*MulW)'(33'h0FFFFFFFF)) ? 32'hFFFFFFFF : di_sum[31:0];
            mreq_r.a <= MulW'(err_r);
            mreq_r.b <= MulW'(step_r);
            state_r <= S_M_HI;
          end
        end
        S_M_HI: begin
          if (mstat.done) begin
            if (hi_sum > (2*MulW)'(32'sh7FFFFFFF)) hint_r <= 32'sh7FFFFFFF;
            else if (hi_sum < -(2*MulW)'(33'sh080000000)) hint_r <= 32'sh80000000;
            else hint_r <= hi_sum[31:0];
            mreq_r.a <= MulW'(dint_r);
            mreq_r.b <= MulW'(lin_ig_r);
            state_r <= S_M_V;
          end
        end
        S_M_V: begin
          if (mstat.done) begin
            lin_r <= (v_sum > (2*MulW)'(32767)) ? 15'h7FFF : v_sum[14:0];
            mreq_r.a <= MulW'(err_r);
            mreq_r.b <= MulW'(ang_gain_r);
            state_r <= S_M_WP;
          end
        end
        S_M_WP: begin
          if (mstat.done) begin
            wacc_r <= 48'(prod >>> 8);
            mreq_r.a <= MulW'(hint_r);
            mreq_r.b <= MulW'(ang_ig_r);
            state_r <= S_M_WI;
          end
        end
        S_M_WI: begin
          if (mstat.done) begin
            if (w_sum > (2*MulW)'(8388607)) ang_r <= 24'sh7FFFFF;
            else if (w_sum < -(2*MulW)'(8388608)) ang_r <= 24'sh800000;
            else ang_r <= w_sum[23:0];
            arr_r <= 1'b0;
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          out_valid_r <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `G2G_ASSERT_IMPL(a_arr_zero, clk, rst_n, out_valid_r && arr_r, (lin_r == '0) && (ang_r == '0), "arrived result carries nonzero speed")
  `G2G_ASSERT_IMPL(a_no_take_busy, clk, rst_n, state_r != S_IDLE, !in_tready, "input taken while busy")
  `G2G_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid_r && !out_tready, out_valid_r, "result dropped before taken")

endmodule

// ===== test/go_to_goal_pi_controller_tb.sv =====
module go_to_goal_pi_controller_tb;
  import g2g_pkg::*;

  // Result word layout, lowest bit first: linear_speed, turn_rate, arrived.
  typedef struct packed {
    logic arrived;
    logic signed [23:0] angular;
    logic [14:0] linear;
  } command_t;

  localparam longint AtanTable [24] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288,
    262144, 131072, 65536, 32768, 16384, 8192,
    4096, 2048, 1024, 512, 256, 128
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [55:0] in_tdata = '0; // op, pos_x, pos_y, heading, zero pad
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [39:0] out_tdata; // linear_speed, turn_rate, arrived
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_wdata = '0;

  // Controller settings and integrals as the predictor sees them.
  logic signed [15:0] goal_x, goal_y;
  logic [14:0] tolerance;
  logic [15:0] ang_gain, lin_igain, ang_igain, period;
  longint dist_integral, head_integral;

  command_t expected_cmds[$];
  int errors = 0;
  int commands_seen = 0;
  int arrivals_seen = 0;
  bit steady = 1'b0;  // when set, neither side idles
  int ready_hold = 0;

  go_to_goal_pi_controller uut (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

  // Expected command for one accepted beat; updates the integrals.
  function automatic command_t predict_command(input logic op, input logic signed [15:0] px,
                                               input logic signed [15:0] py,
                                               input logic signed [15:0] hd);
    command_t r;
    longint x, y, z, t, xs, ys, span, bearing, err, v, w;
    r = '0;
    if (!op) begin
      dist_integral = 0;
      head_integral = 0;
      return r;
    end
    x = (longint'(goal_x) - longint'(px)) * 256;
    y = (longint'(goal_y) - longint'(py)) * 256;
    z = 0;
    // Pre-rotate into the right half plane.
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = 1686629713;
      end else begin
        x = -y; y = t; z = -1686629713;
      end
    end
    for (int i = 0; i < NumSteps; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys; y = y - xs; z = z + AtanTable[i];
      end else begin
        x = x - ys; y = y + xs; z = z - AtanTable[i];
      end
    end
    span = (x * 39797 + (longint'(1) <<< 23)) >>> 24;
    bearing = (z + (longint'(1) <<< 16)) >>> 17;
    if (span <= longint'(tolerance)) begin
      r.arrived = 1'b1;
      return r;
    end
    err = bearing - longint'(hd);
    dist_integral = dist_integral + ((span * longint'(period)) >>> 16);
    if (dist_integral > 64'sh0FFFFFFFF) dist_integral = 64'sh0FFFFFFFF;
    head_integral = head_integral + ((err * longint'(period)) >>> 16);
    if (head_integral > 64'sd2147483647) head_integral = 64'sd2147483647;
    if (head_integral < -64'sd2147483648) head_integral = -64'sd2147483648;
    v = span + ((longint'(lin_igain) * dist_integral) >>> 16);
    if (v > 32767) v = 32767;
    w = ((err * longint'(ang_gain)) >>> 8) + ((head_integral * longint'(ang_igain)) >>> 16);
    if (w > 8388607) w = 8388607;
    if (w < -8388608) w = -8388608;
    r.linear = v[14:0];
    r.angular = w[23:0];
    return r;
  endfunction

  // Receiver stalls: a fresh hold is drawn after every accepted beat.
  always @(posedge clk) begin
    if (out_tvalid && out_tready) begin
      ready_hold = steady ? 0 : $urandom_range(0, 7);
    end else if (ready_hold > 0) begin
      ready_hold = ready_hold - 1;
    end
    out_tready <= (ready_hold == 0);
  end

  // Compare each result beat with the oldest expected command.
  always @(posedge clk) begin
    command_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (expected_cmds.size() == 0) begin
        errors++;
        if (errors <= 10) $display("Unexpected result beat %h", out_tdata);
      end else begin
        want = expected_cmds.pop_front();
        commands_seen++;
        if (got.arrived) arrivals_seen++;
        if (got !== want) begin
          errors++;
          if (errors <= 10) begin
            $display("Mismatch: linear %0d/%0d angular %0d/%0d arrived %0b/%0b (want/got)",
                     want.linear, got.linear, want.angular, got.angular,
                     want.arrived, got.arrived);
          end
        end
      end
    end
  end

  // Send one beat, with a random gap before it unless steady is set, and record its prediction.
  task automatic send_pose(input logic op, input logic [15:0] px, input logic [15:0] py,
                           input logic [15:0] hd);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {7'd0, hd, py, px, op};
    do @(posedge clk); while (!in_tready);
    expected_cmds.push_back(predict_command(op, px, py, hd));
  endtask

  // Wait until every expected command has come back and the block is quiet.
  task automatic drain;
    in_tvalid <= 1'b0;
    while (expected_cmds.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_GOAL_X: goal_x = val;
      REG_GOAL_Y: goal_y = val;
      REG_ARRIVE_TOL: tolerance = val[14:0];
      REG_ANG_GAIN: ang_gain = val;
      REG_LIN_INT_GAIN: lin_igain = val;
      REG_ANG_INT_GAIN: ang_igain = val;
      REG_STEP_TIME: period = val;
      default: ;
    endcase
  endtask

  // Write the whole register set while the block is idle.
  task automatic set_controller(input logic [15:0] gx, input logic [15:0] gy,
                                input logic [15:0] tol, input logic [15:0] kp,
                                input logic [15:0] kil, input logic [15:0] kia,
                                input logic [15:0] dt);
    write_reg(REG_GOAL_X, gx);
    write_reg(REG_GOAL_Y, gy);
    write_reg(REG_ARRIVE_TOL, tol);
    write_reg(REG_ANG_GAIN, kp);
    write_reg(REG_LIN_INT_GAIN, kil);
    write_reg(REG_ANG_INT_GAIN, kia);
    write_reg(REG_STEP_TIME, dt);
    cfg_we <= 1'b0;
  endtask

  // Reset defaults: start of move, arrival, quadrants and field extremes.
  task automatic test_defaults;
    send_pose(1'b0, 16'h0000, 16'h0000, 16'h0000);
    send_pose(1'b1, 16'd8192, 16'd2048, 16'h0000);
    send_pose(1'b1, 16'd8200, 16'd2050, 16'h1234);
    send_pose(1'b1, 16'h0000, 16'h0000, 16'h0000);
    send_pose(1'b1, 16'h7FFF, 16'h0000, 16'h7FFF);
    send_pose(1'b1, 16'h7FFF, 16'h8000, 16'h8000);
    send_pose(1'b1, 16'h8000, 16'h8000, 16'h8000);
    send_pose(1'b1, 16'h8000, 16'h7FFF, 16'h7FFF);
    send_pose(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_pose(1'b1, 16'd8192, 16'd0, 16'h6488);
    send_pose(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    drain();
  endtask

  // Register extremes: largest gains and period, then zero tolerance, gains and period.
  task automatic test_extreme_settings;
    set_controller(16'h8000, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_pose(1'b1, 16'h7FFF, 16'h8000, 16'h0000);
    send_pose(1'b1, 16'h8000, 16'h7FFF, 16'h8000);
    send_pose(1'b1, 16'h8000, 16'h7FFF, 16'h7FFF);
    send_pose(1'b1, 16'h7FFF, 16'h8000, 16'h7FFF);
    send_pose(1'b1, 16'h8000, 16'h7FFF, 16'h8000);
    drain();
    set_controller(16'h7FFF, 16'h8000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_pose(1'b1, 16'h7FFF, 16'h8000, 16'h1111);
    send_pose(1'b1, 16'h8000, 16'h7FFF, 16'h2222);
    send_pose(1'b1, 16'h7FFE, 16'h8000, 16'h3333);
    drain();
  endtask

  // Random phases: new settings, then random pose samples, some near the goal, and clear beats.
  task automatic test_random_moves;
    int n;
    logic [15:0] px, py;
    for (int phase = 0; phase < 10; phase++) begin
      steady = (phase % 4 == 3);
      set_controller(16'($urandom), 16'($urandom), 16'($urandom_range(0, 400)),
                     16'($urandom), 16'($urandom),
                     (phase % 3 == 0) ? 16'd0 : 16'($urandom), 16'($urandom));
      send_pose(1'b0, 16'($urandom), 16'($urandom), 16'($urandom));
      for (n = 0; n < 64; n++) begin
        case ($urandom_range(0, 9))
          0: begin
            send_pose(1'b0, 16'($urandom), 16'($urandom), 16'($urandom));
          end
          1, 2: begin
            px = goal_x + 16'($signed($urandom_range(0, 600)) - 300);
            py = goal_y + 16'($signed($urandom_range(0, 600)) - 300);
            send_pose(1'b1, px, py, 16'($urandom));
          end
          default: begin
            send_pose(1'b1, 16'($urandom), 16'($urandom), 16'($urandom));
          end
        endcase
      end
      drain();
    end
    steady = 1'b0;
  endtask

  initial begin
    goal_x = 16'sd8192;
    goal_y = 16'sd2048;
    tolerance = 15'd20;
    ang_gain = 16'd4096;
    lin_igain = 16'd655;
    ang_igain = 16'd0;
    period = 16'd6554;
    dist_integral = 0;
    head_integral = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_defaults();
    test_extreme_settings();
    test_random_moves();
    $display("Covered %0d commands (%0d arrivals) over default, extreme and random settings.",
             commands_seen, arrivals_seen);
    if (errors == 0 && expected_cmds.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
